[rtl/vwbp_pkg.sv]
// shared types, constants and helpers of the variable width bit packer
package vwbp_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int COUNT_BITS  = 16;
   localparam int WIDTH_BITS  = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] CAPACITY_RESET = 16'd64;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX      = 16'hFFFF;

   // one request: a field and its flush flag
   typedef struct packed {
      logic [BYTE_BITS-1:0]  field_value;
      logic [WIDTH_BITS-1:0] bit_count;
      logic                  last;
   } req_type;

   // one result
   typedef struct packed {
      logic                  byte_valid;
      logic [BYTE_BITS-1:0]  out_byte;
      logic [COUNT_BITS-1:0] bytes_so_far;
      logic                  overflow;
      logic                  bad_width;
      logic                  run_end;
   } rsp_type;

   // results of one request, as queued between front and back
   typedef struct packed {
      logic    two;
      rsp_type first_rsp;
      rsp_type second_rsp;
   } entry_type;

   // byte counter step, holds at full scale
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] count);
      sat_inc = (count == COUNT_MAX) ? count : count + 1'b1;
   endfunction

endpackage

[rtl/vwbp_front.sv]
// front end: takes requests, packs bits into the pending byte, builds result entries
module vwbp_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  vwbp_pkg::req_type                 req_data,
   input  logic                              csr_write_enable,
   input  logic [vwbp_pkg::COUNT_BITS-1:0]   csr_write_data,
   input  logic                              queue_full,
   output logic                              push,
   output vwbp_pkg::entry_type               push_entry
);
   import vwbp_pkg::*;

   logic [BYTE_BITS-1:0]  partial_ff, partial_in;
   logic [2:0]            filled_ff, filled_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic [COUNT_BITS-1:0] capacity_ff, capacity_in;

   logic                  accept;
   logic                  bad;
   logic [3:0]            room, take, rest;
   logic [BYTE_BITS-1:0]  low, high, merged;
   logic                  complete, flush;
   logic [BYTE_BITS-1:0]  partial_1;
   logic [2:0]            filled_1;
   logic [COUNT_BITS-1:0] total_1, total_2;
   rsp_type               rsp_full, rsp_flush, rsp_bad;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // classify the width and split the field at the byte boundary
   always_comb begin
      bad    = !(req_data.bit_count inside {[4'd1:4'd8]});
      room   = 4'd8 - {1'b0, filled_ff};
      take   = (req_data.bit_count > room) ? room : req_data.bit_count;
      rest   = req_data.bit_count - take;
      low    = req_data.field_value & (8'hFF >> (4'd8 - take));
      high   = (req_data.field_value >> take) & (8'hFF >> (4'd8 - rest));
      merged = partial_ff | (low << (room - take));
   end

   // state after the field, then after an optional flush
   always_comb begin
      complete  = !bad && (take == room);
      partial_1 = partial_ff;
      filled_1  = filled_ff;
      total_1   = total_ff;
      if (complete) begin
         partial_1 = high << (4'd8 - rest);
         filled_1  = rest[2:0];
         total_1   = sat_inc(total_ff);
      end else if (!bad) begin
         partial_1 = merged;
         filled_1  = filled_ff + take[2:0];
      end
      flush   = req_data.last && (filled_1 != 3'd0);
      total_2 = flush ? sat_inc(total_1) : total_1;
   end

   // the three kinds of result
   always_comb begin
      rsp_full.byte_valid   = 1'b1;
      rsp_full.out_byte     = merged;
      rsp_full.bytes_so_far = total_1;
      rsp_full.overflow     = ({1'b0, total_1} + 17'(filled_1 != 3'd0)) > {1'b0, capacity_ff};
      rsp_full.bad_width    = bad;
      rsp_full.run_end      = !flush;

      rsp_flush.byte_valid   = 1'b1;
      rsp_flush.out_byte     = partial_1;
      rsp_flush.bytes_so_far = total_2;
      rsp_flush.overflow     = total_2 > capacity_ff;
      rsp_flush.bad_width    = bad;
      rsp_flush.run_end      = 1'b1;

      rsp_bad.byte_valid   = 1'b0;
      rsp_bad.out_byte     = '0;
      rsp_bad.bytes_so_far = total_ff;
      rsp_bad.overflow     = ({1'b0, total_ff} + 17'(filled_ff != 3'd0)) > {1'b0, capacity_ff};
      rsp_bad.bad_width    = 1'b1;
      rsp_bad.run_end      = 1'b1;
   end

   // queue entry for this request
   always_comb begin
      push                  = accept && (complete || flush || bad);
      push_entry.two        = complete && flush;
      push_entry.first_rsp  = complete ? rsp_full : (flush ? rsp_flush : rsp_bad);
      push_entry.second_rsp = rsp_flush;
   end

   // next state
   always_comb begin
      partial_in  = partial_ff;
      filled_in   = filled_ff;
      total_in    = total_ff;
      capacity_in = csr_write_enable ? csr_write_data : capacity_ff;
      if (accept) begin
         partial_in = flush ? '0 : partial_1;
         filled_in  = flush ? 3'd0 : filled_1;
         total_in   = total_2;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff  <= '0;
         filled_ff   <= '0;
         total_ff    <= '0;
         capacity_ff <= CAPACITY_RESET;
      end else begin
         partial_ff  <= partial_in;
         filled_ff   <= filled_in;
         total_ff    <= total_in;
         capacity_ff <= capacity_in;
      end
   end

endmodule

[rtl/vwbp_queue.sv]
// short queue of result entries between front and back
module vwbp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  vwbp_pkg::entry_type   push_entry,
   input  logic                  pop,
   output logic                  full,
   output logic                  not_empty,
   output vwbp_pkg::entry_type   head
);
   import vwbp_pkg::*;

   entry_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue push while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH)) else $error("queue count out of range");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");
`endif

endmodule

[rtl/vwbp_back.sv]
// back end: hands out the one or two results of each queued entry
module vwbp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  not_empty,
   input  vwbp_pkg::entry_type   head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vwbp_pkg::rsp_type     rsp_data
);
   import vwbp_pkg::*;

   logic sel_ff, sel_in;
   logic done_entry;
   logic accept;

   // pick the current result of the head entry
   always_comb begin
      rsp_valid  = not_empty;
      rsp_data   = sel_ff ? head.second_rsp : head.first_rsp;
      accept     = rsp_valid && rsp_ready;
      done_entry = !head.two || sel_ff;
      pop        = accept && done_entry;
      sel_in     = sel_ff;
      if (accept) begin
         sel_in = !done_entry;
      end
   end

   // result select
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

endmodule

[rtl/variable_width_bit_packer.sv]
// top level of the variable width bit packer
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   req_data  (vwbp_pkg::req_type)
//   rsp       out        rsp_valid / rsp_ready   rsp_data  (vwbp_pkg::rsp_type)
//   csr       in         csr_write_enable        csr_write_data (capacity_bytes)
//
// one request per cycle while the queue has room; a request that yields two results
// holds the back end for both, so the rate is set by results: one result per cycle
// at the rsp port while rsp_ready is high; results reach rsp through a two-entry queue
// reset is synchronous; capacity_bytes comes back as 64 and all packing state clears
// req_ready falls only when the queue is full, so rsp stalls reach req after two entries
module variable_width_bit_packer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  vwbp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output vwbp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write_enable,
   input  logic [vwbp_pkg::COUNT_BITS-1:0]   csr_write_data
);
   import vwbp_pkg::*;

   logic      push, pop, full, not_empty;
   entry_type push_entry, head;

   // packing and classification
   vwbp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (full),
      .push             (push),
      .push_entry       (push_entry)
   );

   // decoupling queue
   vwbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   // result delivery
   vwbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/tb_variable_width_bit_packer.sv]
// self-checking testbench of the variable width bit packer
`timescale 1ns / 1ps

module tb_variable_width_bit_packer;
   import vwbp_pkg::*;

   localparam int HALF_PERIOD    = 2;
   localparam int RESET_CYCLES   = 8;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int IDLE_LIMIT     = 4000;
   localparam int REPORT_LIMIT   = 40;
   localparam int PHASE_ITEMS    = 160;
   localparam int WIDTH_MAX      = 8;

   // one directed request, with its result typed in where it is obvious
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  csr_write_enable;
   logic [COUNT_BITS-1:0] csr_write_data;

   // packer state as predicted
   logic [BYTE_BITS-1:0]  packer_partial;
   logic [2:0]            packer_filled;
   logic [COUNT_BITS-1:0] packer_total;
   logic [COUNT_BITS-1:0] capacity_model;

   rsp_type pending_results[$];
   stim_row_type directed_rows[$];

   int sender_idle_pct;
   int receiver_stall_pct;
   logic holdoff_request;
   int holdoff_left;
   int idle_count;
   int error_count;
   int requests_sent;
   int results_checked;
   int overflow_seen;
   int bad_seen;
   rsp_type oldest;

   variable_width_bit_packer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // result fields for the current predicted state
   function automatic rsp_type packer_result(input logic valid, input int byte_value,
                                             input logic bad);
      rsp_type r;
      int size;
      size = int'(packer_total) + ((packer_filled != 3'd0) ? 1 : 0);
      r.byte_valid   = valid;
      r.out_byte     = valid ? 8'(byte_value) : 8'h00;
      r.bytes_so_far = packer_total;
      r.overflow     = (size > int'(capacity_model));
      r.bad_width    = bad;
      r.run_end      = 1'b0;
      return r;
   endfunction

   // byte counter, holds at full scale
   task automatic count_packed_byte();
      if (packer_total != COUNT_MAX) begin
         packer_total = packer_total + 1'b1;
      end
   endtask

   // packs one field into the predicted state and queues the results it causes
   task automatic predict_packing(input req_type item);
      rsp_type outs [2];
      int n;
      int bits;
      int room;
      int take;
      int rest;
      int low_part;
      int high_part;
      int partial;
      logic bad;
      n = 0;
      bits = int'(item.bit_count);
      bad = (bits == 0) || (bits > WIDTH_MAX);
      if (!bad) begin
         room = WIDTH_MAX - int'(packer_filled);
         take = (bits > room) ? room : bits;
         rest = bits - take;
         low_part = int'(item.field_value) & ((1 << take) - 1);
         high_part = (int'(item.field_value) >> take) & ((1 << rest) - 1);
         partial = (int'(packer_partial) | (low_part << (room - take))) & 8'hFF;
         if (take == room) begin
            count_packed_byte();
            packer_partial = 8'((high_part << (WIDTH_MAX - rest)) & 8'hFF);
            packer_filled = 3'(rest);
            outs[n] = packer_result(1'b1, partial, bad);
            n++;
         end else begin
            packer_partial = 8'(partial);
            packer_filled = 3'(int'(packer_filled) + take);
         end
      end
      // flush of a pending partial byte
      if (item.last && packer_filled != 3'd0) begin
         partial = int'(packer_partial);
         count_packed_byte();
         packer_partial = 8'h00;
         packer_filled = 3'd0;
         outs[n] = packer_result(1'b1, partial, bad);
         n++;
      end
      // a bad width with no byte still reports
      if (n == 0 && bad) begin
         outs[n] = packer_result(1'b0, 0, bad);
         n++;
      end
      if (n > 0) begin
         outs[n-1].run_end = 1'b1;
      end
      for (int k = 0; k < n; k++) begin
         pending_results.push_back(outs[k]);
      end
   endtask

   // offers one request, idling first as the phase asks, and predicts on acceptance
   task automatic send_field(input req_type item, input logic typed, input rsp_type want);
      int before_count;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      requests_sent++;
      before_count = pending_results.size();
      predict_packing(item);
      if (typed) begin
         while (pending_results.size() > before_count) begin
            void'(pending_results.pop_back());
         end
         pending_results.push_back(want);
      end
   endtask

   // waits until every expected result is in, then lets the pipeline settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // capacity write, only with the block idle
   task automatic write_capacity(input logic [COUNT_BITS-1:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      capacity_model = value;
      csr_write_enable <= 1'b0;
   endtask

   // mostly well-formed fields, with bad widths and flushes mixed in
   function automatic req_type random_field();
      req_type item;
      int pick;
      item.field_value = 8'($urandom_range(0, 255));
      if ($urandom_range(99) < 10) begin
         pick = $urandom_range(0, 7);
         item.bit_count = (pick == 0) ? 4'd0 : 4'(pick + WIDTH_MAX);
      end else begin
         item.bit_count = 4'($urandom_range(1, WIDTH_MAX));
      end
      item.last = ($urandom_range(99) < 12);
      return item;
   endfunction

   task automatic run_phase(input int count, input int idle_pct, input int stall_pct,
                            input int holdoff_at);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i == holdoff_at) begin
            holdoff_request = 1'b1;
         end
         send_field(random_field(), 1'b0, '0);
      end
   endtask

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
         end
      end
   endtask

   // row of the directed table
   task automatic add_row(input logic [7:0] value, input logic [3:0] bits, input logic last,
                          input logic typed, input rsp_type want);
      stim_row_type row;
      row.item.field_value = value;
      row.item.bit_count = bits;
      row.item.last = last;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t unexpected result: expected none, actual %0h", $time, rsp_data);
         end else begin
            oldest = pending_results.pop_front();
            report_field("byte_valid", oldest.byte_valid, rsp_data.byte_valid);
            report_field("out_byte", oldest.out_byte, rsp_data.out_byte);
            report_field("bytes_so_far", oldest.bytes_so_far, rsp_data.bytes_so_far);
            report_field("overflow", oldest.overflow, rsp_data.overflow);
            report_field("bad_width", oldest.bad_width, rsp_data.bad_width);
            report_field("run_end", oldest.run_end, rsp_data.run_end);
            results_checked++;
            if (oldest.overflow) overflow_seen++;
            if (oldest.bad_width) bad_seen++;
         end
      end
      if (holdoff_request) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_request = 1'b0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count = 0;
      end else begin
         idle_count++;
      end
      if (idle_count >= IDLE_LIMIT) begin
         $display("%0t watchdog: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      rsp_ready <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      packer_partial = 8'h00;
      packer_filled = 3'd0;
      packer_total = '0;
      capacity_model = CAPACITY_RESET;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      holdoff_request = 1'b0;
      holdoff_left = 0;
      idle_count = 0;
      error_count = 0;
      requests_sent = 0;
      results_checked = 0;
      overflow_seen = 0;
      bad_seen = 0;

      // typed results as {byte_valid, out_byte, bytes_so_far, overflow, bad_width, run_end}
      add_row(8'h00, 4'd0,  1'b0, 1'b1, {1'b0, 8'h00, 16'd0, 1'b0, 1'b1, 1'b1});
      add_row(8'hFF, 4'd15, 1'b0, 1'b1, {1'b0, 8'h00, 16'd0, 1'b0, 1'b1, 1'b1});
      add_row(8'hFF, 4'd8,  1'b0, 1'b1, {1'b1, 8'hFF, 16'd1, 1'b0, 1'b0, 1'b1});
      add_row(8'h00, 4'd8,  1'b0, 1'b1, {1'b1, 8'h00, 16'd2, 1'b0, 1'b0, 1'b1});
      // high bits above the width are dropped; the first two complete one byte
      add_row(8'hFF, 4'd1,  1'b0, 1'b0, '0);
      add_row(8'h3F, 4'd7,  1'b0, 1'b0, '0);
      add_row(8'h05, 4'd3,  1'b0, 1'b0, '0);
      // split across bytes, then flush: two results
      add_row(8'hA5, 4'd8,  1'b1, 1'b0, '0);
      add_row(8'h0F, 4'd4,  1'b1, 1'b0, '0);
      // bad width with last and nothing pending
      add_row(8'h00, 4'd0,  1'b1, 1'b0, '0);
      // bad width still flushes a pending byte
      add_row(8'h03, 4'd2,  1'b0, 1'b0, '0);
      add_row(8'h00, 4'd9,  1'b1, 1'b0, '0);
      // last on a byte-aligned field: no padding byte
      add_row(8'h5A, 4'd8,  1'b1, 1'b0, '0);
      add_row(8'h1F, 4'd5,  1'b0, 1'b0, '0);
      add_row(8'h2A, 4'd6,  1'b0, 1'b0, '0);
      add_row(8'h55, 4'd7,  1'b0, 1'b0, '0);
      add_row(8'h01, 4'd1,  1'b0, 1'b0, '0);
      add_row(8'h80, 4'd8,  1'b1, 1'b0, '0);
      add_row(8'h0C, 4'd4,  1'b0, 1'b0, '0);
      // bad width with a partial byte pending and no flush
      add_row(8'hF0, 4'd12, 1'b0, 1'b0, '0);
      add_row(8'hFF, 4'd0,  1'b1, 1'b0, '0);
      add_row(8'h06, 4'd3,  1'b1, 1'b0, '0);
      add_row(8'hAA, 4'd8,  1'b0, 1'b0, '0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset capacity
      foreach (directed_rows[i]) begin
         send_field(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end

      // random phases over capacity settings and idling patterns
      write_capacity(16'd1);
      run_phase(PHASE_ITEMS, 0, 0, 40);
      write_capacity(16'(packer_total + 16'd60));
      run_phase(PHASE_ITEMS, 53, 0, -1);
      write_capacity(COUNT_MAX);
      run_phase(PHASE_ITEMS, 0, 53, -1);
      write_capacity(16'(packer_total + 16'd50));
      run_phase(PHASE_ITEMS, 35, 35, -1);
      write_capacity(16'd0);
      run_phase(PHASE_ITEMS, 35, 35, -1);

      // last mixed phase at full capacity
      write_capacity(COUNT_MAX);
      run_phase(40, 35, 35, -1);

      wait_drained();
      $display("%0d requests sent, %0d results checked (%0d overflow, %0d bad width)",
               requests_sent, results_checked, overflow_seen, bad_seen);
      $display("capacities 64, 1, 0, mid and full scale; idling, stalls and a long hold-off");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
